// ===== hdl/eddth_pkg.sv =====
// ----------------------------------------------------------------------------
// eddth_pkg
// Shared types, constants and helpers of the error diffusion dither block.
// ----------------------------------------------------------------------------
package eddth_pkg;

  // Frame geometry
  localparam int MAX_WIDTH = 1024;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);
  localparam int WIDTH_W   = 11;

  // Number formats: pixel values are Q8, errors are signed Q8
  localparam int PIX_W     = 8;
  localparam int FRAC_BITS = 8;
  localparam int VAL_W     = PIX_W + FRAC_BITS;
  localparam int ERR_W     = 17;
  localparam int SUM_W     = VAL_W + 3;
  localparam int WGT_W     = 5;

  typedef logic signed [ERR_W-1:0] err_t;
  typedef err_t [2:0] err3_t;

  localparam err_t ERR_ZERO = '0;

  // Luminance weights, Q8 (77R + 151G + 28B) / 256; FRAC_BITS equals 8 so no shift
  localparam logic [VAL_W-1:0] LUM_R = VAL_W'(77);
  localparam logic [VAL_W-1:0] LUM_G = VAL_W'(151);
  localparam logic [VAL_W-1:0] LUM_B = VAL_W'(28);

  // Kernel weights in 32nds: row 0 Floyd-Steinberg, row 1 Burkes
  localparam logic [WGT_W-1:0] RIGHT_W [2][2] = '{
    '{5'd14, 5'd0},
    '{5'd8,  5'd4}
  };
  localparam logic [WGT_W-1:0] BELOW_W [2][5] = '{
    '{5'd0, 5'd6, 5'd10, 5'd2, 5'd0},
    '{5'd2, 5'd4, 5'd8,  5'd4, 5'd2}
  };

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_LINE_WIDTH    = 2'd0,
    CFG_GRAY_MODE     = 2'd1,
    CFG_KERNEL_SELECT = 2'd2
  } cfg_index_e;

  // Per-channel control from the compute stage
  typedef struct packed {
    logic fire;
    logic frame_start;
    logic use_line;
    logic row_end;
    logic kernel;
  } chan_ctrl_t;

  // One write into the error line, all three channels at one column
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    err3_t             data;
  } lb_wr_t;

  // error * weight / 32, rounded toward minus infinity
  function automatic err_t tap(input err_t e, input logic [WGT_W-1:0] w);
    logic signed [ERR_W+WGT_W:0] p;
    p = e * $signed({1'b0, w});
    return p[ERR_W+WGT_W-1:WGT_W];
  endfunction

endpackage

// ===== hdl/eddth_if.sv =====
// ----------------------------------------------------------------------------
// eddth stream channels
// Valid/ready channels for incoming RGB pixels and dithered result pixels.
// ----------------------------------------------------------------------------
interface eddth_pix_in_if
  import eddth_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;
  logic             frame_start;

  modport source (output valid, red_in, green_in, blue_in, frame_start, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, frame_start, output ready);
endinterface

interface eddth_pix_out_if
  import eddth_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

// ===== hdl/eddth_linebuf.sv =====
// ----------------------------------------------------------------------------
// eddth_linebuf
// Error line memory for the next row, one write port and one registered read
// port, with a short queue for the extra writes at the end of a row and
// forwarding of writes the registered read has not seen.
// ----------------------------------------------------------------------------
module eddth_linebuf
  import eddth_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // read issued when an item is accepted
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  // column c-2 write from the compute stage
  input  lb_wr_t            wr,
  // row end writes for columns c-1 and c
  input  lb_wr_t            enq_a,
  input  lb_wr_t            enq_b,
  // compute stage is empty or moving, so the queue may drain
  input  logic              drain_ok,
  // column of the item in the compute stage and its line errors
  input  logic [ADDR_W-1:0] lk_addr,
  output err3_t             lk_data
);

  localparam int Q_DEPTH = 3;
  localparam logic [1:0] Q_FULL = 2'(Q_DEPTH);

  err3_t             mem [MAX_WIDTH];
  err3_t             rd_data;
  logic              lw_valid;
  logic [ADDR_W-1:0] lw_addr;
  err3_t             lw_data;

  logic [ADDR_W-1:0] q_addr [Q_DEPTH];
  err3_t             q_data [Q_DEPTH];
  logic [1:0]        q_cnt;
  logic [ADDR_W-1:0] q_addr_next [Q_DEPTH];
  err3_t             q_data_next [Q_DEPTH];
  logic [1:0]        q_cnt_next;

  logic              drain;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  err3_t             mem_wd;

  // write port: compute stage first, queue head when the port is free
  assign drain  = (q_cnt != 2'd0) && !wr.en && drain_ok;
  assign mem_we = wr.en || drain;
  assign mem_wa = wr.en ? wr.addr : q_addr[0];
  assign mem_wd = wr.en ? wr.data : q_data[0];

  // memory and registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      lw_addr <= mem_wa;
      lw_data <= mem_wd;
    end
  end

  // remembers whether the read edge also carried a write
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (rd_en) begin
      lw_valid <= mem_we;
    end
  end

  // queue: pop the head, then append the row end entries
  always_comb begin
    q_addr_next = q_addr;
    q_data_next = q_data;
    q_cnt_next  = q_cnt;
    if (drain) begin
      for (int i = 0; i < Q_DEPTH - 1; i++) begin
        q_addr_next[i] = q_addr[i+1];
        q_data_next[i] = q_data[i+1];
      end
      q_cnt_next = q_cnt - 2'd1;
    end
    if (enq_a.en && q_cnt_next != Q_FULL) begin
      q_addr_next[q_cnt_next] = enq_a.addr;
      q_data_next[q_cnt_next] = enq_a.data;
      q_cnt_next = q_cnt_next + 2'd1;
    end
    if (enq_b.en && q_cnt_next != Q_FULL) begin
      q_addr_next[q_cnt_next] = enq_b.addr;
      q_data_next[q_cnt_next] = enq_b.data;
      q_cnt_next = q_cnt_next + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    q_addr <= q_addr_next;
    q_data <= q_data_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= 2'd0;
    end else begin
      q_cnt <= q_cnt_next;
    end
  end

  // forwarding: queued entries are newest, then the write at the read edge
  always_comb begin
    lk_data = rd_data;
    if (lw_valid && lw_addr == lk_addr) begin
      lk_data = lw_data;
    end
    for (int i = 0; i < Q_DEPTH; i++) begin
      if (2'(i) < q_cnt && q_addr[i] == lk_addr) begin
        lk_data = q_data[i];
      end
    end
  end

endmodule

// ===== hdl/eddth_chan.sv =====
// ----------------------------------------------------------------------------
// eddth_chan
// One color channel: sum, clamp, threshold and error spread, with the
// carries to the right and the window of next-row errors.
// ----------------------------------------------------------------------------
module eddth_chan
  import eddth_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  chan_ctrl_t       ctrl,
  input  logic [VAL_W-1:0] value,
  input  err_t             line,
  output logic             level,
  output err_t             col_m2,
  output err_t             col_m1,
  output err_t             col_0
);

  localparam logic signed [SUM_W-1:0] TOP_Q  = SUM_W'(255 << FRAC_BITS);
  localparam logic signed [SUM_W-1:0] HALF_Q = SUM_W'(128 << FRAC_BITS);
  localparam logic signed [SUM_W-1:0] ZERO_Q = '0;

  err_t       carry0;
  err_t       carry1;
  err_t [3:0] bw;

  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] clamped;
  err_t                    err;
  err_t                    line_term;
  err_t                    c0_base;
  err_t                    c1_base;
  err_t [4:0]              bw_add;
  err_t                    carry0_next;
  err_t                    carry1_next;

  // frame start drops the row state before this item
  assign c0_base   = ctrl.frame_start ? ERR_ZERO : carry0;
  assign c1_base   = ctrl.frame_start ? ERR_ZERO : carry1;
  assign line_term = ctrl.use_line ? line : ERR_ZERO;

  // sum, clamp once, threshold
  always_comb begin
    sum = $signed({{(SUM_W-VAL_W){1'b0}}, value}) + SUM_W'(c0_base) + SUM_W'(line_term);
    if (sum < ZERO_Q) begin
      clamped = ZERO_Q;
    end else if (sum > TOP_Q) begin
      clamped = TOP_Q;
    end else begin
      clamped = sum;
    end
    level = (clamped >= HALF_Q);
    err   = ERR_W'(clamped - (level ? TOP_Q : ZERO_Q));
  end

  // spread the error; the far right column of the window starts empty
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (!ctrl.frame_start) begin
        bw_add[k] = bw[k] + tap(err, BELOW_W[ctrl.kernel][k]);
      end else begin
        bw_add[k] = tap(err, BELOW_W[ctrl.kernel][k]);
      end
    end
    bw_add[4]   = tap(err, BELOW_W[ctrl.kernel][4]);
    carry0_next = c1_base + tap(err, RIGHT_W[ctrl.kernel][0]);
    carry1_next = tap(err, RIGHT_W[ctrl.kernel][1]);
  end

  assign col_m2 = bw_add[0];
  assign col_m1 = bw_add[1];
  assign col_0  = bw_add[2];

  // row state: shift the window, clear at row end
  always_ff @(posedge clk) begin
    if (rst) begin
      carry0 <= '0;
      carry1 <= '0;
      bw     <= '0;
    end else if (ctrl.fire) begin
      if (ctrl.row_end) begin
        carry0 <= '0;
        carry1 <= '0;
        bw     <= '0;
      end else begin
        carry0 <= carry0_next;
        carry1 <= carry1_next;
        for (int k = 0; k < 4; k++) begin
          bw[k] <= bw_add[k+1];
        end
      end
    end
  end

endmodule

// ===== hdl/error_diffusion_dither.sv =====
// ----------------------------------------------------------------------------
// error_diffusion_dither
// Streaming Floyd-Steinberg / Burkes error diffusion to 0/255 per channel.
// ----------------------------------------------------------------------------
// Usage:
//   pixel  - RGB items in raster order, frame_start set on the first pixel
//            of each frame. An item moves when valid and ready are high.
//   result - one dithered item per input item, every channel 0 or 255.
//   cfg_*  - register writes (line width, gray mode, kernel select), taken
//            on any edge with cfg_write high; write them only while idle.
// Timing: one item per clock sustained while result.ready stays high. An
//   accepted item goes into the compute register and then into the result
//   register before it shows on result. This path is set by the registered
//   read of the error line memory ahead of the single compute stage.
// Stall: the result register holds while result.ready is low; the compute
//   stage holds behind it and pixel.ready drops only when both are full.
// Reset: registers return to width 640, color mode, Floyd-Steinberg, first
//   row of a frame; the error line needs no clearing since the first row
//   never reads it.
// ----------------------------------------------------------------------------
module error_diffusion_dither
  import eddth_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  eddth_pix_in_if.sink         pixel,
  eddth_pix_out_if.source      result,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [WIDTH_W-1:0]   cfg_data
);

  typedef struct packed {
    logic [PIX_W-1:0]  red;
    logic [PIX_W-1:0]  green;
    logic [PIX_W-1:0]  blue;
    logic [VAL_W-1:0]  lum;
    logic              frame_start;
    logic              first_row;
    logic              row_end;
    logic [ADDR_W-1:0] col;
  } item_t;

  // configuration
  logic [WIDTH_W-1:0] line_width;
  logic               gray_mode;
  logic               kernel_select;

  // column tracking
  logic [ADDR_W-1:0]  column_count;
  logic               first_row;
  logic [WIDTH_W-1:0] w_eff;
  logic [ADDR_W-1:0]  in_col;
  logic               in_first;
  logic               in_row_end;
  logic [VAL_W-1:0]   in_lum;
  logic               in_fire;

  // compute stage
  item_t              s1;
  logic               s1_valid;
  logic               s1_fire;
  chan_ctrl_t         ctrl;
  logic [2:0][VAL_W-1:0] ch_val;
  err3_t              line_err;
  err3_t              wr_m2;
  err3_t              wr_m1;
  err3_t              wr_0;
  logic [2:0]         ch_level;
  lb_wr_t             wr;
  lb_wr_t             enq_a;
  lb_wr_t             enq_b;

  // result register
  logic               out_valid;
  logic [PIX_W-1:0]   red_q;
  logic [PIX_W-1:0]   green_q;
  logic [PIX_W-1:0]   blue_q;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width    <= WIDTH_W'(640);
      gray_mode     <= 1'b0;
      kernel_select <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_LINE_WIDTH:    line_width    <= cfg_data;
        CFG_GRAY_MODE:     gray_mode     <= cfg_data[0];
        CFG_KERNEL_SELECT: kernel_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_fire     = s1_valid && (!out_valid || result.ready);
  assign pixel.ready = !s1_valid || s1_fire;
  assign in_fire     = pixel.valid && pixel.ready;

  // column of the incoming item and row end
  always_comb begin
    if (line_width == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (line_width > WIDTH_W'(MAX_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = line_width;
    end
    in_col     = pixel.frame_start ? '0 : column_count;
    in_first   = pixel.frame_start || first_row;
    in_row_end = (WIDTH_W'(in_col) + WIDTH_W'(1)) >= w_eff;
    in_lum     = LUM_R * VAL_W'(pixel.red_in) + LUM_G * VAL_W'(pixel.green_in)
               + LUM_B * VAL_W'(pixel.blue_in);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      first_row    <= 1'b1;
    end else if (in_fire) begin
      column_count <= in_row_end ? '0 : in_col + ADDR_W'(1);
      first_row    <= in_row_end ? 1'b0 : in_first;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1.red         <= pixel.red_in;
      s1.green       <= pixel.green_in;
      s1.blue        <= pixel.blue_in;
      s1.lum         <= in_lum;
      s1.frame_start <= pixel.frame_start;
      s1.first_row   <= in_first;
      s1.row_end     <= in_row_end;
      s1.col         <= in_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel.ready) begin
      s1_valid <= pixel.valid;
    end
  end

  // error line memory
  eddth_linebuf u_linebuf (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (in_fire),
    .rd_addr  (in_col),
    .wr       (wr),
    .enq_a    (enq_a),
    .enq_b    (enq_b),
    .drain_ok (!s1_valid || s1_fire),
    .lk_addr  (s1.col),
    .lk_data  (line_err)
  );

  // channel datapaths; gray mode runs luminance through the red channel
  assign ctrl.fire        = s1_fire;
  assign ctrl.frame_start = s1.frame_start;
  assign ctrl.use_line    = !s1.first_row;
  assign ctrl.row_end     = s1.row_end;
  assign ctrl.kernel      = kernel_select;

  assign ch_val[0] = gray_mode ? s1.lum : {s1.red, FRAC_BITS'(0)};
  assign ch_val[1] = {s1.green, FRAC_BITS'(0)};
  assign ch_val[2] = {s1.blue, FRAC_BITS'(0)};

  for (genvar ch = 0; ch < 3; ch++) begin : g_chan
    eddth_chan u_chan (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .value  (ch_val[ch]),
      .line   (line_err[ch]),
      .level  (ch_level[ch]),
      .col_m2 (wr_m2[ch]),
      .col_m1 (wr_m1[ch]),
      .col_0  (wr_0[ch])
    );
  end

  // finished next-row columns: c-2 from column 2 on, c-1 and c at row end
  always_comb begin
    wr.en      = s1_fire && (s1.col >= ADDR_W'(2));
    wr.addr    = s1.col - ADDR_W'(2);
    wr.data    = wr_m2;
    enq_a.en   = s1_fire && s1.row_end && (s1.col >= ADDR_W'(1));
    enq_a.addr = s1.col - ADDR_W'(1);
    enq_a.data = wr_m1;
    enq_b.en   = s1_fire && s1.row_end;
    enq_b.addr = s1.col;
    enq_b.data = wr_0;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      red_q   <= {PIX_W{ch_level[0]}};
      green_q <= {PIX_W{gray_mode ? ch_level[0] : ch_level[1]}};
      blue_q  <= {PIX_W{gray_mode ? ch_level[0] : ch_level[2]}};
    end
  end

  assign result.valid     = out_valid;
  assign result.red_out   = red_q;
  assign result.green_out = green_q;
  assign result.blue_out  = blue_q;

endmodule
